FILE: rtl/core/tsd_pkg.sv
// Shared constants for the tilt switch debouncer: widths, register indexes, reset values.
`default_nettype none

package tsd_pkg;

  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_PERIOD     = 8'd1;

  // Reset values
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd5;
  localparam logic [CNT_W-1:0] PERIOD_RESET    = 8'd5;

  // Orientation codes
  localparam logic ORIENT_VERTICAL   = 1'b0;
  localparam logic ORIENT_HORIZONTAL = 1'b1;

  typedef logic [CNT_W-1:0] count_t;

  function automatic count_t sat_inc(input count_t v);
    return (v < CNT_MAX) ? count_t'(v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tilt_switch_debouncer_unit.sv
// Top level of the tilt switch debouncer: start-up majority vote and up/down integrator.
`default_nettype none

// Channel   Signals                                   Direction  Notes
// sample    sample_valid/ready, pin_level, restart    input      one tick per transfer
// result    result_valid/ready, event_valid,          output     one result per sample
//           orientation, in_startup
// cfg       cfg_valid/ready, cfg_index, cfg_data      input      always ready
//
// A sample is taken when sample_valid and sample_ready are both high: the state
// registers update on that transfer and the result lands in one output register
// the next cycle. The result register alone sets the rate; a sample transfers
// while the previous result is taken, so throughput is one item per clock while
// result_ready is high. sample_ready drops only with an untaken result held.
// Synchronous reset sets config and state and clears result_valid, not the data.

module tilt_switch_debouncer_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           sample_valid,
  output logic                          sample_ready,
  input  wire                           pin_level,
  input  wire                           restart,
  output logic                          result_valid,
  input  wire                           result_ready,
  output logic                          event_valid,
  output logic                          orientation,
  output logic                          in_startup,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tsd_pkg::*;

  // Configuration registers
  count_t debounce_threshold;
  count_t startup_period;

  // Debouncer state
  logic   startup_flag;
  count_t high_count;
  count_t low_count;
  count_t tick_integrator;
  logic   current_orientation;

  logic   startup_flag_next;
  count_t high_count_next;
  count_t low_count_next;
  count_t tick_integrator_next;
  logic   current_orientation_next;
  logic   event_next;

  logic   sample_xfer;
  logic   result_xfer;
  count_t tick_inc;
  count_t high_inc;
  count_t low_inc;

  assign cfg_ready    = 1'b1;
  // Accept a new sample unless an untaken result sits in the output register.
  assign sample_ready = !result_valid || result_ready;
  assign sample_xfer  = sample_valid && sample_ready;
  assign result_xfer  = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_threshold <= THRESHOLD_RESET;
      startup_period     <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE_THRESHOLD: debounce_threshold <= count_t'(cfg_data);
        REG_STARTUP_PERIOD:     startup_period     <= count_t'(cfg_data);
        default: ;
      endcase
    end
  end

  assign tick_inc = sat_inc(tick_integrator);
  assign high_inc = pin_level ? sat_inc(high_count) : high_count;
  assign low_inc  = pin_level ? low_count : sat_inc(low_count);

  always_comb begin
    startup_flag_next        = startup_flag;
    high_count_next          = high_count;
    low_count_next           = low_count;
    tick_integrator_next     = tick_integrator;
    current_orientation_next = current_orientation;
    event_next               = 1'b0;
    if (restart) begin
      // Restart the vote; take the sample as orientation, count nothing.
      startup_flag_next        = 1'b1;
      high_count_next          = '0;
      low_count_next           = '0;
      tick_integrator_next     = '0;
      current_orientation_next = pin_level;
    end else if (startup_flag) begin
      high_count_next      = high_inc;
      low_count_next       = low_inc;
      tick_integrator_next = tick_inc;
      // End the vote once the period is reached; ties go vertical.
      if (tick_inc >= startup_period) begin
        tick_integrator_next     = '0;
        current_orientation_next = (high_inc > low_inc) ? ORIENT_HORIZONTAL
                                                        : ORIENT_VERTICAL;
        startup_flag_next        = 1'b0;
        event_next               = 1'b1;
      end
    end else begin
      // Integrate disagreement; decay toward zero on agreement; flip at the threshold.
      if (pin_level != current_orientation) begin
        tick_integrator_next = tick_inc;
      end else if (tick_integrator != '0) begin
        tick_integrator_next = tick_integrator - 1'b1;
      end
      if (tick_integrator_next >= debounce_threshold) begin
        tick_integrator_next     = '0;
        current_orientation_next = pin_level;
        event_next               = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_flag        <= 1'b1;
      high_count          <= '0;
      low_count           <= '0;
      tick_integrator     <= '0;
      current_orientation <= ORIENT_VERTICAL;
    end else if (sample_xfer) begin
      startup_flag        <= startup_flag_next;
      high_count          <= high_count_next;
      low_count           <= low_count_next;
      tick_integrator     <= tick_integrator_next;
      current_orientation <= current_orientation_next;
    end
  end

  // Result register: load on every sample transfer, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (sample_xfer) begin
      result_valid <= 1'b1;
    end else if (result_xfer) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      event_valid <= event_next;
      orientation <= current_orientation_next;
      in_startup  <= startup_flag_next;
    end
  end

  // A start-up decision leaves the start-up phase; a restart never emits.
  a_event_not_startup: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_valid |-> !in_startup)
    else $error("event reported while still in start-up");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    sample_xfer && restart |=> startup_flag && tick_integrator == '0 &&
      high_count == '0 && low_count == '0 && !event_valid)
    else $error("restart did not clear the vote state");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    sample_xfer |=> result_valid && orientation == current_orientation &&
      in_startup == startup_flag)
    else $error("result register out of step with state");

  a_startup_stays_off: assert property (@(posedge clk) disable iff (rst)
    sample_xfer && !restart && !startup_flag |=> !startup_flag)
    else $error("start-up phase reentered without restart");

endmodule

`default_nettype wire
